[hw/rtl/fue_pkg.sv]
// ============================================================================
// fue_pkg: shared types, constants and functions of the form URL encoder
// Holds the character codes, the queue entry type and the classification
// helpers used by the front and back parts.
// ============================================================================
package fue_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned QueueDepth = 4;

  localparam logic [ByteW-1:0] ChSpace   = 8'h20;
  localparam logic [ByteW-1:0] ChPlus    = 8'h2B;
  localparam logic [ByteW-1:0] ChAmp     = 8'h26;
  localparam logic [ByteW-1:0] ChEqual   = 8'h3D;
  localparam logic [ByteW-1:0] ChPercent = 8'h25;
  localparam logic [ByteW-1:0] ChColon   = 8'h3A;
  localparam logic [ByteW-1:0] ChCr      = 8'h0D;
  localparam logic [ByteW-1:0] ChLf      = 8'h0A;

  // One queued command: either a literal byte or a byte to escape as %XY.
  typedef struct packed {
    logic             escape;
    logic [ByteW-1:0] data;
  } fue_cmd_t;

  localparam int unsigned CmdW = $bits(fue_cmd_t);

  // Status of the queue as seen by the back part.
  typedef struct packed {
    logic     not_empty;
    fue_cmd_t head;
  } fue_head_t;

  function automatic logic passes_through(input logic [ByteW-1:0] c);
    logic ok;
    ok = c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                   8'h5F, 8'h2D, 8'h2E, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29};
    return ok;
  endfunction

  function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] v);
    logic [ByteW-1:0] d;
    if (v < 4'd10) begin
      d = 8'h30 + {4'd0, v};
    end else begin
      d = 8'h41 + {4'd0, v} - 8'd10;
    end
    return d;
  endfunction

endpackage

[hw/rtl/fue_front.sv]
// ============================================================================
// fue_front: input classification
// Accepts raw bytes, tracks the key flag and turns each byte into at most
// one queue command. Carriage returns are accepted and dropped.
// ============================================================================
module fue_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fue_pkg::ByteW-1:0]     in_byte,
  input  logic                          in_first_of_text,
  input  logic                          q_full,
  output logic                          q_push,
  output fue_pkg::fue_cmd_t             q_cmd
);

  logic key_seen_r;
  logic key_seen_nxt;
  logic key_now;
  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign key_now  = in_first_of_text ? 1'b0 : key_seen_r;

  always_comb begin
    key_seen_nxt = key_seen_r;
    q_push       = 1'b0;
    q_cmd.escape = 1'b0;
    q_cmd.data   = in_byte;
    if (accept) begin
      key_seen_nxt = key_now;
      q_push       = 1'b1;
      if (in_byte == fue_pkg::ChSpace) begin
        q_cmd.data = fue_pkg::ChPlus;
      end else if (fue_pkg::passes_through(in_byte)) begin
        q_cmd.data = in_byte;
      end else if (in_byte == fue_pkg::ChCr) begin
        q_push = 1'b0;
      end else if (in_byte == fue_pkg::ChLf) begin
        key_seen_nxt = 1'b0;
        q_cmd.data   = fue_pkg::ChAmp;
      end else if (in_byte == fue_pkg::ChColon && !key_now) begin
        key_seen_nxt = 1'b1;
        q_cmd.data   = fue_pkg::ChEqual;
      end else begin
        q_cmd.escape = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_seen_r <= 1'b0;
    end else begin
      key_seen_r <= key_seen_nxt;
    end
  end

endmodule

[hw/rtl/fue_queue.sv]
// ============================================================================
// fue_queue: command queue
// A small register queue between the front and back parts; the head entry
// is presented to the back part every cycle.
// ============================================================================
module fue_queue #(
  parameter int unsigned DEPTH = fue_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fue_pkg::fue_cmd_t   push_cmd,
  input  logic                pop,
  output logic                full,
  output fue_pkg::fue_head_t  head
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  fue_pkg::fue_cmd_t mem_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r,  count_nxt;
  logic              do_push, do_pop;

  assign full           = (count_r == FullCnt);
  assign head.not_empty = (count_r != '0);
  assign head.head      = mem_r[rd_ptr_r];
  assign do_push        = push && !full;
  assign do_pop         = pop && head.not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[hw/rtl/fue_back.sv]
// ============================================================================
// fue_back: output sequencer
// Expands the queue head into one or three output beats and holds each beat
// in an output register until it is taken.
// ============================================================================
module fue_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fue_pkg::fue_head_t            head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fue_pkg::ByteW-1:0]     out_byte,
  output logic                          out_last_of_run
);

  localparam logic [1:0] PhLead = 2'd0;
  localparam logic [1:0] PhHigh = 2'd1;
  localparam logic [1:0] PhLow  = 2'd2;

  logic [1:0]                phase_r, phase_nxt;
  logic                      valid_r, valid_nxt;
  logic [fue_pkg::ByteW-1:0] byte_r,  byte_nxt;
  logic                      last_r,  last_nxt;
  logic                      load;

  assign load = head.not_empty && (!valid_r || !out_stall);

  always_comb begin
    phase_nxt = phase_r;
    valid_nxt = valid_r && out_stall;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      if (!head.head.escape) begin
        byte_nxt = head.head.data;
        last_nxt = 1'b1;
        pop      = 1'b1;
      end else begin
        case (phase_r)
          PhLead: begin
            byte_nxt  = fue_pkg::ChPercent;
            last_nxt  = 1'b0;
            phase_nxt = PhHigh;
          end
          PhHigh: begin
            byte_nxt  = fue_pkg::hex_digit(head.head.data[7:4]);
            last_nxt  = 1'b0;
            phase_nxt = PhLow;
          end
          PhLow: begin
            byte_nxt  = fue_pkg::hex_digit(head.head.data[3:0]);
            last_nxt  = 1'b1;
            phase_nxt = PhLead;
            pop       = 1'b1;
          end
          default: begin
            phase_nxt = PhLead;
            valid_nxt = valid_r && out_stall;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PhLead;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_last_of_run = last_r;

endmodule

[hw/rtl/form_url_encoder.sv]
// ============================================================================
// form_url_encoder: form-style URL encoder, one raw byte per input beat
// Path: a result beat passes through a queue entry and then the output register
//   before it appears at the output.
// Throughput: one input beat per cycle for bytes that give one result beat,
//   while the output is not stalled; a percent-escaped byte gives three beats;
//   the single output port of the back sequencer, one beat per cycle, sets this rate.
// Reset: synchronous, active low; the key flag, queue pointers and output valid are cleared.
// ============================================================================
//
// The design has three parts. The front part classifies each accepted byte
// and updates the key flag at once, so that the flag is always current for
// the next input beat. It turns the byte into one command: a literal byte
// (pass-through characters, '+', '&' or '=') or a byte to escape. Carriage
// returns are accepted and produce no command.
//
// Commands wait in a short register queue. The back part expands the head
// command into one beat, or into three beats '%', high hex digit, low hex
// digit, and pops it once its final beat is loaded into the output register.
// The last beat of each run carries out_last_of_run.
//
// The front part stalls only while the queue is full, so a run of escaped
// bytes fills the queue and then paces the input to one byte per three output beats.
module form_url_encoder #(
  parameter int unsigned QUEUE_DEPTH = fue_pkg::QueueDepth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fue_pkg::ByteW-1:0]     in_byte,
  input  logic                          in_first_of_text,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fue_pkg::ByteW-1:0]     out_byte,
  output logic                          out_last_of_run
);

  logic               q_full;
  logic               q_push;
  logic               q_pop;
  fue_pkg::fue_cmd_t  q_cmd;
  fue_pkg::fue_head_t q_head;

  // Classification and key flag.
  fue_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_first_of_text (in_first_of_text),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_cmd)
  );

  // Decoupling queue between the two sides.
  fue_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .head     (q_head)
  );

  // Beat expansion and output register.
  fue_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

[hw/rtl/fue_checker.sv]
// ============================================================================
// fue_checker: port-level checks of the form URL encoder
// Watches the top-level ports only and is bound to every instance.
// ============================================================================
module fue_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [fue_pkg::ByteW-1:0]     out_byte,
  input logic                          out_last_of_run
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last_of_run))
    else $error("stalled output beat changed");

  // Nothing is shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // A percent sign always opens an escape and never ends a run.
  a_percent_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte == fue_pkg::ChPercent |-> !out_last_of_run)
    else $error("percent sign marked last of run");

  // Only escape beats are not last: '%' or an upper-case hex digit.
  a_mid_run_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |->
      out_byte == fue_pkg::ChPercent ||
      (out_byte >= 8'h30 && out_byte <= 8'h39) ||
      (out_byte >= 8'h41 && out_byte <= 8'h46))
    else $error("unexpected byte inside an escape run");

endmodule

bind form_url_encoder fue_checker u_fue_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_last_of_run (out_last_of_run)
);
